// ----- rtl/core/mfps_pkg.sv -----
// Shared widths, limits and types for the maximum falling path sum block.
package mfps_pkg;

  localparam int MAX_COLUMNS_DEF = 1024;
  localparam int CFG_W           = 11;
  localparam int CELL_W          = 16;
  localparam int SUM_W           = 32;

  typedef logic signed [SUM_W-1:0] sum_t;

  localparam sum_t SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam sum_t SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

endpackage

// ----- rtl/core/mfps_row_mem.sv -----
// Row buffer of path sums: one write port and two registered read ports.
module mfps_row_mem #(
  parameter int DEPTH  = mfps_pkg::MAX_COLUMNS_DEF,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [ADDR_W-1:0]          wr_addr,
  input  logic [mfps_pkg::SUM_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [ADDR_W-1:0]          rd_addr_a,
  input  logic [ADDR_W-1:0]          rd_addr_b,
  output logic [mfps_pkg::SUM_W-1:0] rd_data_a,
  output logic [mfps_pkg::SUM_W-1:0] rd_data_b
);
  import mfps_pkg::*;

  logic [SUM_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Reads return the contents before a same-cycle write; the caller forwards.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

// ----- rtl/core/max_falling_path_sum_unit.sv -----
// Top level of the streaming maximum falling path sum engine.
//
// Grid cells arrive one transaction at a time in row-major order, with the
// row length taken from the cfg register (zero counts as one column, values
// above MAX_COLUMNS count as MAX_COLUMNS). Unless input is held off, the
// block accepts one cell per clock cycle, each in the cycle it is offered,
// and each path sum is written back from the update stage; the sustained rate
// is one cell per cycle, set by the row buffer, a synchronous memory with
// one write and two read ports. A cell reads the sums above it and
// above-right of it from the buffer when accepted; the above-left sum is the
// value the previous cell read before overwriting it. On the cell flagged
// grid_end, the best sum of the current row and a sticky saturation flag
// appear on the result channel at the same edge as the write-back. The
// result sits in an output register, so input keeps flowing while it waits;
// only a second grid end arriving while the first result is still unclaimed
// holds off input. Sums clamp at the signed 32-bit limits. There is no
// clearing pass after reset: the row buffer is always written before a value
// read from it is used within a grid. The user must change the row length
// only while no transaction is in flight; the block does not enforce this.
module max_falling_path_sum_unit #(
  parameter int MAX_COLUMNS = mfps_pkg::MAX_COLUMNS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [mfps_pkg::CFG_W-1:0]  cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [mfps_pkg::CELL_W-1:0] in_cell_value,
  input  logic                        in_grid_end,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [mfps_pkg::SUM_W-1:0]  out_best_path_sum,
  output logic                        out_sum_saturated
);
  import mfps_pkg::*;

  localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int LEN_W = $clog2(MAX_COLUMNS + 1);

  // Per-cell control that travels from the accept stage to the update stage.
  typedef struct packed {
    logic             grid_end;
    logic             first_row;
    logic             has_left;
    logic             has_right;
    logic             row_done;
    logic             fwd_up;
    logic             fwd_right;
    logic [COL_W-1:0] col;
  } s2_ctl_t;

  // Configuration register.
  logic [CFG_W-1:0] row_length_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_length_r <= CFG_W'(1);
    end else if (cfg_wr_en) begin
      row_length_r <= cfg_wr_data;
    end
  end

  // Effective row length, limited to the range the buffer supports.
  logic [31:0]      len_wide;
  logic [31:0]      len_lim;
  logic [LEN_W-1:0] row_len;

  always_comb begin
    len_wide = 32'(row_length_r);
    if (len_wide == 32'd0) begin
      len_lim = 32'd1;
    end else if (len_wide > 32'(MAX_COLUMNS)) begin
      len_lim = 32'(MAX_COLUMNS);
    end else begin
      len_lim = len_wide;
    end
    row_len = len_lim[LEN_W-1:0];
  end

  // Accept stage: column tracking and buffer read-ahead.
  logic             in_accept;
  logic             s2_adv;
  logic [COL_W-1:0] column_index_r, column_index_nxt;
  logic             in_first_row_r, in_first_row_nxt;
  logic [LEN_W-1:0] col_ext;
  logic [COL_W-1:0] col_eff;
  logic [LEN_W-1:0] col_inc;
  logic             has_right;
  logic [COL_W-1:0] rd_addr_right;

  always_comb begin
    col_ext = LEN_W'(column_index_r);
    // A column past the current row length is taken as the last column.
    if (col_ext >= row_len) begin
      col_eff = COL_W'(row_len - LEN_W'(1));
    end else begin
      col_eff = column_index_r;
    end
    col_inc       = LEN_W'(col_eff) + LEN_W'(1);
    has_right     = col_inc < row_len;
    rd_addr_right = has_right ? col_inc[COL_W-1:0] : col_eff;
  end

  always_comb begin
    column_index_nxt = column_index_r;
    in_first_row_nxt = in_first_row_r;
    if (in_accept) begin
      if (in_grid_end) begin
        column_index_nxt = '0;
        in_first_row_nxt = 1'b1;
      end else if (!has_right) begin
        column_index_nxt = '0;
        in_first_row_nxt = 1'b0;
      end else begin
        column_index_nxt = col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_index_r <= '0;
      in_first_row_r <= 1'b1;
    end else begin
      column_index_r <= column_index_nxt;
      in_first_row_r <= in_first_row_nxt;
    end
  end

  // Update stage registers.
  logic                     s2_valid_r;
  s2_ctl_t                  s2_ctl_r;
  logic signed [CELL_W-1:0] s2_cell_r;
  sum_t                     byp_r;
  sum_t                     left_old_r;
  sum_t                     row_best_r;
  logic                     sat_seen_r;
  logic                     out_valid_r;
  sum_t                     out_best_r;
  logic                     out_sat_r;

  logic [SUM_W-1:0] rd_up, rd_right;
  sum_t             fresh;

  mfps_row_mem #(
    .DEPTH (MAX_COLUMNS),
    .ADDR_W(COL_W)
  ) u_row_mem (
    .clk      (clk),
    .wr_en    (s2_adv),
    .wr_addr  (s2_ctl_r.col),
    .wr_data  (fresh),
    .rd_en    (in_accept),
    .rd_addr_a(col_eff),
    .rd_addr_b(rd_addr_right),
    .rd_data_a(rd_up),
    .rd_data_b(rd_right)
  );

  // The update stage stalls only on a grid end that finds the output full.
  assign s2_adv    = s2_valid_r && (!s2_ctl_r.grid_end || !out_valid_r || out_ready);
  assign in_ready  = !s2_valid_r || s2_adv;
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (in_accept) begin
      s2_valid_r <= 1'b1;
    end else if (s2_adv) begin
      s2_valid_r <= 1'b0;
    end
  end

  // A write landing in the same cycle as the read is forwarded around the
  // buffer; this happens when a short row wraps onto itself.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s2_cell_r          <= $signed(in_cell_value);
      s2_ctl_r.grid_end  <= in_grid_end;
      s2_ctl_r.first_row <= in_first_row_r;
      s2_ctl_r.has_left  <= col_eff != '0;
      s2_ctl_r.has_right <= has_right;
      s2_ctl_r.row_done  <= !has_right;
      s2_ctl_r.fwd_up    <= s2_adv && (s2_ctl_r.col == col_eff);
      s2_ctl_r.fwd_right <= s2_adv && (s2_ctl_r.col == rd_addr_right);
      s2_ctl_r.col       <= col_eff;
      byp_r              <= fresh;
    end
  end

  // Path sum of the cell in the update stage.
  sum_t                  up_sum, right_sum, best_above, row_best_new;
  logic signed [SUM_W:0] sum_wide;
  logic                  sat_hit;

  always_comb begin
    up_sum    = s2_ctl_r.fwd_up    ? byp_r : $signed(rd_up);
    right_sum = s2_ctl_r.fwd_right ? byp_r : $signed(rd_right);
    best_above = up_sum;
    if (s2_ctl_r.has_left && (left_old_r > best_above)) begin
      best_above = left_old_r;
    end
    if (s2_ctl_r.has_right && (right_sum > best_above)) begin
      best_above = right_sum;
    end
    sum_wide = (SUM_W+1)'(s2_cell_r) + (SUM_W+1)'(best_above);
    sat_hit  = 1'b0;
    if (s2_ctl_r.first_row) begin
      fresh = SUM_W'(s2_cell_r);
    end else if (sum_wide > (SUM_W+1)'(SUM_MAX)) begin
      fresh   = SUM_MAX;
      sat_hit = 1'b1;
    end else if (sum_wide < (SUM_W+1)'(SUM_MIN)) begin
      fresh   = SUM_MIN;
      sat_hit = 1'b1;
    end else begin
      fresh = sum_wide[SUM_W-1:0];
    end
    row_best_new = (fresh > row_best_r) ? fresh : row_best_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_old_r <= '0;
      row_best_r <= SUM_MIN;
      sat_seen_r <= 1'b0;
    end else if (s2_adv) begin
      left_old_r <= up_sum;
      if (s2_ctl_r.grid_end) begin
        row_best_r <= SUM_MIN;
        sat_seen_r <= 1'b0;
      end else begin
        row_best_r <= s2_ctl_r.row_done ? SUM_MIN : row_best_new;
        sat_seen_r <= sat_seen_r | sat_hit;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_adv && s2_ctl_r.grid_end) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s2_ctl_r.grid_end) begin
      out_best_r <= row_best_new;
      out_sat_r  <= sat_seen_r | sat_hit;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_best_path_sum = out_best_r;
  assign out_sum_saturated = out_sat_r;

endmodule

// ----- rtl/core/mfps_checker.sv -----
// Port-level assertions for the maximum falling path sum block, with its bind.
module mfps_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_grid_end,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [mfps_pkg::SUM_W-1:0]  out_best_path_sum,
  input logic                        out_sum_saturated
);
  import mfps_pkg::*;

  // A result that is not taken stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_best_path_sum)
      && $stable(out_sum_saturated))
    else $error("result changed while stalled");

  // No result is pending right after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Input is held off only behind a result that is waiting to be taken.
  a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  // A fresh result follows a grid-end transaction.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_grid_end, 2))
    else $error("result without a grid-end transaction");

endmodule

bind max_falling_path_sum_unit mfps_checker u_mfps_checker (.*);
